[sv/tftpd_pkg.sv]
// Shared types and constants for the TFTP extended packet deframer.
`timescale 1ns / 1ps

package tftpd_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int COUNT_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [15:0] OPC_RESYNC = 16'hFFFF;
  localparam logic [15:0] OPC_MAX = 16'd10;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_RRQ   = 4'd1;
  localparam logic [3:0] OP_WRQ   = 4'd2;
  localparam logic [3:0] OP_DATA  = 4'd3;
  localparam logic [3:0] OP_ACK   = 4'd4;
  localparam logic [3:0] OP_ERROR = 4'd5;
  localparam logic [3:0] OP_DIRQ  = 4'd6;
  localparam logic [3:0] OP_LOGRQ = 4'd7;
  localparam logic [3:0] OP_DELRQ = 4'd8;
  localparam logic [3:0] OP_BCAST = 4'd9;
  localparam logic [3:0] OP_DISC  = 4'd10;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_t;

  typedef struct packed {
    logic [3:0]  packet_type;
    kind_t       item_kind;
    logic [7:0]  data_byte;
    logic [15:0] block_number;
    logic [15:0] data_size;
    logic [15:0] error_code;
    logic [7:0]  add_flag;
    logic        last;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

[sv/tftpd_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface tftpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface tftpd_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  packet_type;
  logic [1:0]  item_kind;
  logic [7:0]  data_byte;
  logic [15:0] block_number;
  logic [15:0] data_size;
  logic [15:0] error_code;
  logic [7:0]  add_flag;
  logic        last;

  modport source (output valid, output packet_type, output item_kind, output data_byte,
                  output block_number, output data_size, output error_code,
                  output add_flag, output last, input ready);
  modport sink (input valid, input packet_type, input item_kind, input data_byte,
                input block_number, input data_size, input error_code,
                input add_flag, input last, output ready);
endinterface

[sv/tftpd_front.sv]
// Front end: takes bytes, tracks packet framing, classifies each byte into a result.
`timescale 1ns / 1ps

module tftpd_front
  import tftpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tftpd_byte_if.sink rx,
  input  logic      queue_full,
  output logic      push,
  output result_t   push_data
);

  logic [3:0]         opcode;
  logic [3:0]         opcode_next;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [7:0]         opcode_high;
  logic [7:0]         opcode_high_next;
  logic [15:0]        size;
  logic [15:0]        size_next;
  logic [15:0]        block;
  logic [15:0]        block_next;
  logic [15:0]        code;
  logic [15:0]        code_next;
  logic [7:0]         flag;
  logic [7:0]         flag_next;

  logic               take;
  logic [7:0]         b;
  logic [15:0]        op;
  logic               done;
  logic               emit;
  logic [7:0]         done_byte;
  logic [COUNT_W-1:0] pos;
  result_t            res;

  assign rx.ready = !queue_full;
  assign take     = rx.valid && rx.ready;
  assign b        = rx.byte_in;
  assign op       = {opcode_high, b};
  assign pos      = byte_count;

  always_comb begin
    opcode_next      = opcode;
    byte_count_next  = byte_count;
    opcode_high_next = opcode_high;
    size_next        = size;
    block_next       = block;
    code_next        = code;
    flag_next        = flag;
    done             = 1'b0;
    emit             = 1'b0;
    done_byte        = 8'd0;
    res              = '0;

    if (opcode == OP_NONE) begin
      if (byte_count == '0) begin
        opcode_high_next = b;
        byte_count_next  = COUNT_W'(1);
      end else begin
        byte_count_next  = '0;
        opcode_high_next = 8'd0;
        if (op == OPC_RESYNC) begin
          // resync marker, nothing to report
        end else if (op == 16'd0 || op > OPC_MAX) begin
          emit           = 1'b1;
          res.item_kind  = KIND_UNKNOWN;
        end else begin
          opcode_next     = op[3:0];
          byte_count_next = COUNT_W'(2);
          if (op[3:0] == OP_DIRQ || op[3:0] == OP_DISC) begin
            done = 1'b1;
          end
        end
      end
    end else begin
      byte_count_next = (pos < COUNT_MAX) ? pos + COUNT_W'(1) : COUNT_MAX;
      case (opcode)
        OP_RRQ, OP_WRQ, OP_LOGRQ, OP_DELRQ: begin
          if (b == 8'd0) done = 1'b1;
          else emit = 1'b1;
        end
        OP_DATA: begin
          if (pos == COUNT_W'(2)) begin
            size_next = {b, 8'd0};
          end else if (pos == COUNT_W'(3)) begin
            size_next = {size[15:8], b};
          end else if (pos == COUNT_W'(4)) begin
            block_next = {b, 8'd0};
          end else if (pos == COUNT_W'(5)) begin
            block_next = {block[15:8], b};
            if (size == 16'd0) done = 1'b1;
          end else if ((pos - COUNT_W'(5)) >= {1'b0, size}) begin
            done      = 1'b1;
            done_byte = b;
          end else begin
            emit = 1'b1;
          end
        end
        OP_ACK: begin
          if (pos == COUNT_W'(2)) begin
            block_next = {b, 8'd0};
          end else begin
            block_next = {block[15:8], b};
            done       = 1'b1;
          end
        end
        OP_ERROR: begin
          if (pos == COUNT_W'(2)) begin
            code_next = {b, 8'd0};
          end else if (pos == COUNT_W'(3)) begin
            code_next = {code[15:8], b};
          end else if (b == 8'd0) begin
            done = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        OP_BCAST: begin
          // the flag byte is never a terminator
          if (pos == COUNT_W'(2)) flag_next = b;
          else if (b == 8'd0) done = 1'b1;
          else emit = 1'b1;
        end
        default: begin
          opcode_next      = OP_NONE;
          byte_count_next  = '0;
          opcode_high_next = 8'd0;
          size_next        = 16'd0;
          block_next       = 16'd0;
          code_next        = 16'd0;
          flag_next        = 8'd0;
        end
      endcase

      if (emit) begin
        res.packet_type = opcode;
        res.item_kind   = KIND_BYTE;
        res.data_byte   = b;
      end
    end

    if (done) begin
      emit            = 1'b1;
      res.packet_type = opcode_next;
      res.item_kind   = KIND_DONE;
      res.data_byte   = done_byte;
      res.last        = 1'b1;
      if (opcode_next == OP_DATA || opcode_next == OP_ACK) res.block_number = block_next;
      if (opcode_next == OP_DATA) res.data_size = size_next;
      if (opcode_next == OP_ERROR) res.error_code = code_next;
      if (opcode_next == OP_BCAST) res.add_flag = flag_next;
      opcode_next      = OP_NONE;
      byte_count_next  = '0;
      opcode_high_next = 8'd0;
      size_next        = 16'd0;
      block_next       = 16'd0;
      code_next        = 16'd0;
      flag_next        = 8'd0;
    end
  end

  assign push      = take && emit;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode      <= OP_NONE;
      byte_count  <= '0;
      opcode_high <= 8'd0;
      size        <= 16'd0;
      block       <= 16'd0;
      code        <= 16'd0;
      flag        <= 8'd0;
    end else if (take) begin
      opcode      <= opcode_next;
      byte_count  <= byte_count_next;
      opcode_high <= opcode_high_next;
      size        <= size_next;
      block       <= block_next;
      code        <= code_next;
      flag        <= flag_next;
    end
  end

endmodule

[sv/tftpd_queue.sv]
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps

module tftpd_queue
  import tftpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  result_t       push_data,
  input  logic          pop,
  output result_t       head,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  result_t           mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == FULL_CNT);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/tftpd_back.sv]
// Back end: output register that drains the queue onto the result channel.
`timescale 1ns / 1ps

module tftpd_back
  import tftpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  queue_status_t   q_status,
  input  result_t         head,
  output logic            pop,
  tftpd_result_if.source  tx
);

  logic    out_valid;
  result_t out_data;

  assign pop = !q_status.empty && (!out_valid || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= head;
  end

  assign tx.valid        = out_valid;
  assign tx.packet_type  = out_data.packet_type;
  assign tx.item_kind    = out_data.item_kind;
  assign tx.data_byte    = out_data.data_byte;
  assign tx.block_number = out_data.block_number;
  assign tx.data_size    = out_data.data_size;
  assign tx.error_code   = out_data.error_code;
  assign tx.add_flag     = out_data.add_flag;
  assign tx.last         = out_data.last;

endmodule

[sv/tftp_ext_packet_deframer_unit.sv]
// Top level of the TFTP extended packet deframer.
`timescale 1ns / 1ps

// Takes one received byte per cycle on rx and frames extended TFTP packets
// (opcodes 1..10; 0xFFFF is a silent resync, any other opcode gives an
// unknown-opcode result). Each byte yields at most one result on tx: a name,
// text or payload byte, a completion carrying the header fields, or an
// unknown-opcode flag. The framing state updates as each byte is taken, so a
// new byte is taken every cycle; results pass through a QUEUE_DEPTH-entry
// queue and one output register, and rx.ready drops only while that queue
// is full. A result is written into the queue, then the output register.
module tftp_ext_packet_deframer_unit
  import tftpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  tftpd_byte_if.sink     rx,
  tftpd_result_if.source tx
);

  logic          push;
  logic          pop;
  result_t       push_data;
  result_t       head;
  queue_status_t q_status;

  tftpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .queue_full (q_status.full),
    .push       (push),
    .push_data  (push_data)
  );

  tftpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tftpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .tx       (tx)
  );

  // a result is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("push into full queue");

  // queued results reach the idle output register the next cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!tx.valid && !q_status.empty) |=> tx.valid)
    else $error("queue not drained into output stage");

  // a completion result always carries last
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.item_kind == KIND_DONE) |-> push_data.last)
    else $error("completion without last");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for tftp_ext_packet_deframer_unit: byte stream in, checked results out.
`timescale 1ns / 1ps

module tb_top;
  import tftpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1260;
  localparam int PRINT_LIMIT = 40;
  localparam logic [7:0] NUL = 8'h00;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_STARVED} sink_mode_t;

  // Tracks the framing state of the deframer and holds the results it owes.
  class frame_scoreboard;
    result_t     expected_q[$];
    int          errors;
    int          n_bytes;
    int          n_results;
    int          n_text;
    int          n_done;
    int          n_unknown;
    logic [15:0] types_done;
    logic [3:0]  cur_op;
    logic [16:0] byte_pos;
    logic [7:0]  op_high;
    logic [15:0] size_r;
    logic [15:0] block_r;
    logic [15:0] code_r;
    logic [7:0]  flag_r;

    function new();
      errors = 0;
      n_bytes = 0;
      n_results = 0;
      n_text = 0;
      n_done = 0;
      n_unknown = 0;
      types_done = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      cur_op = OP_NONE;
      byte_pos = '0;
      op_high = '0;
      size_r = '0;
      block_r = '0;
      code_r = '0;
      flag_r = '0;
    endfunction

    function void push_text_byte(logic [7:0] b);
      result_t r;
      r = '0;
      r.packet_type = cur_op;
      r.item_kind = KIND_BYTE;
      r.data_byte = b;
      expected_q = {expected_q, r};
    endfunction

    function void push_done(logic [7:0] b);
      result_t r;
      r = '0;
      r.packet_type = cur_op;
      r.item_kind = KIND_DONE;
      r.data_byte = b;
      if (cur_op == OP_DATA || cur_op == OP_ACK) r.block_number = block_r;
      if (cur_op == OP_DATA) r.data_size = size_r;
      if (cur_op == OP_ERROR) r.error_code = code_r;
      if (cur_op == OP_BCAST) r.add_flag = flag_r;
      r.last = 1'b1;
      expected_q = {expected_q, r};
      clear_frame();
    endfunction

    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [16:0] pos;
      logic [15:0] op_word;
      n_bytes++;
      if (cur_op == OP_NONE) begin
        if (byte_pos == '0) begin
          op_high = b;
          byte_pos = 17'd1;
          return;
        end
        op_word = {op_high, b};
        byte_pos = '0;
        op_high = '0;
        if (op_word == OPC_RESYNC) return;
        if (op_word == 16'(OP_NONE) || op_word > OPC_MAX) begin
          r = '0;
          r.item_kind = KIND_UNKNOWN;
          expected_q = {expected_q, r};
          return;
        end
        cur_op = op_word[3:0];
        byte_pos = 17'd2;
        if (cur_op == OP_DIRQ || cur_op == OP_DISC) push_done(NUL);
        return;
      end
      pos = byte_pos;
      if (byte_pos != COUNT_MAX) byte_pos = byte_pos + 17'd1;
      case (cur_op)
        OP_RRQ, OP_WRQ, OP_LOGRQ, OP_DELRQ: begin
          if (b == NUL) push_done(NUL);
          else push_text_byte(b);
        end
        OP_DATA: begin
          if (pos == 17'd2) size_r = {b, 8'h00};
          else if (pos == 17'd3) size_r[7:0] = b;
          else if (pos == 17'd4) block_r = {b, 8'h00};
          else if (pos == 17'd5) begin
            block_r[7:0] = b;
            if (size_r == 16'd0) push_done(NUL);
          end else if (pos - 17'd5 >= {1'b0, size_r}) push_done(b);
          else push_text_byte(b);
        end
        OP_ACK: begin
          if (pos == 17'd2) block_r = {b, 8'h00};
          else begin
            block_r[7:0] = b;
            push_done(NUL);
          end
        end
        OP_ERROR: begin
          // code bytes are never terminators, even when zero
          if (pos == 17'd2) code_r = {b, 8'h00};
          else if (pos == 17'd3) code_r[7:0] = b;
          else if (b == NUL) push_done(NUL);
          else push_text_byte(b);
        end
        OP_BCAST: begin
          if (pos == 17'd2) flag_r = b;
          else if (b == NUL) push_done(NUL);
          else push_text_byte(b);
        end
        default: clear_frame();
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what, logic [15:0] got_v, logic [15:0] want_v);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, n_results, what, got_v, want_v);
    endtask

    task check_result(result_t got);
      result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected result, packet_type", got.packet_type, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.packet_type !== want.packet_type)
        report("packet_type", got.packet_type, want.packet_type);
      if (got.item_kind !== want.item_kind) report("item_kind", got.item_kind, want.item_kind);
      if (got.data_byte !== want.data_byte) report("data_byte", got.data_byte, want.data_byte);
      if (got.block_number !== want.block_number)
        report("block_number", got.block_number, want.block_number);
      if (got.data_size !== want.data_size) report("data_size", got.data_size, want.data_size);
      if (got.error_code !== want.error_code)
        report("error_code", got.error_code, want.error_code);
      if (got.add_flag !== want.add_flag) report("add_flag", got.add_flag, want.add_flag);
      if (got.last !== want.last) report("last", got.last, want.last);
      case (want.item_kind)
        KIND_BYTE: n_text++;
        KIND_DONE: begin
          n_done++;
          types_done[want.packet_type] = 1'b1;
        end
        default: n_unknown++;
      endcase
    endtask
  endclass

  logic clk;
  logic rst;
  int   idle_cycles;
  logic [7:0] stim_q[$];
  frame_scoreboard sb = new();

  tftpd_byte_if   rx_if();
  tftpd_result_if tx_if();

  tftp_ext_packet_deframer_unit u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---- stimulus building ----

  function automatic void put_word(ref logic [7:0] q[$], input logic [15:0] w);
    q = {q, w[15:8], w[7:0]};
  endfunction

  function automatic void put_text(ref logic [7:0] q[$], input int n);
    repeat (n) q = {q, 8'($urandom_range(1, 255))};
    q = {q, NUL};
  endfunction

  // biased toward all-zero / all-one halves
  function automatic logic [15:0] corner_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {8'($urandom), 8'h00};
      3: return {8'h00, 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(25, 300);
    return $urandom_range(0, 24);
  endfunction

  function automatic void build_packet(ref logic [7:0] q[$], input logic [3:0] op,
                                       input int text_len, input int dsize);
    logic [15:0] w;
    put_word(q, 16'(op));
    case (op)
      OP_RRQ, OP_WRQ, OP_LOGRQ, OP_DELRQ: put_text(q, text_len);
      OP_DATA: begin
        put_word(q, dsize[15:0]);
        put_word(q, corner_word());
        repeat (dsize) q = {q, 8'($urandom)};
      end
      OP_ACK: put_word(q, corner_word());
      OP_ERROR: begin
        put_word(q, corner_word());
        put_text(q, text_len);
      end
      OP_BCAST: begin
        w = corner_word();
        q = {q, w[7:0]};
        put_text(q, text_len);
      end
      default: ;
    endcase
  endfunction

  // ---- driving ----

  task automatic send_byte(input logic [7:0] b);
    rx_if.valid <= 1'b1;
    rx_if.byte_in <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
  endtask

  task automatic drive_stream();
    int burst_left;
    bit steady;
    burst_left = 0;
    steady = 1'b0;
    while (stim_q.size() != 0) begin
      if (burst_left == 0) begin
        if (!steady && $urandom_range(0, 2) != 0) begin
          rx_if.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 9) == 0) steady = !steady;
      end
      send_byte(stim_q.pop_front());
      burst_left--;
    end
    rx_if.valid <= 1'b0;
  endtask

  initial begin
    sink_mode_t mode;
    int left;
    int phase;
    mode = SINK_OPEN;
    left = 0;
    phase = 0;
    tx_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      phase++;
      case (mode)
        SINK_OPEN: tx_if.ready <= 1'b1;
        SINK_COIN: tx_if.ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: tx_if.ready <= (phase % 7) < 3;
        default: tx_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---- monitoring ----

  always @(posedge clk) begin
    result_t got;
    if (!rst && rx_if.valid && rx_if.ready) sb.note_byte(rx_if.byte_in);
    if (!rst && tx_if.valid && tx_if.ready) begin
      got.packet_type = tx_if.packet_type;
      got.item_kind = kind_t'(tx_if.item_kind);
      got.data_byte = tx_if.data_byte;
      got.block_number = tx_if.block_number;
      got.data_size = tx_if.data_size;
      got.error_code = tx_if.error_code;
      got.add_flag = tx_if.add_flag;
      got.last = tx_if.last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, sb.pending());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---- main sequence ----

  initial begin
    logic [7:0] pkt[$];
    int pick;
    int random_start;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.byte_in = '0;

    // directed: resync, unknown opcodes at both ends, bodiless packets, empty names,
    // max ACK block, zero-size DATA, zero ERROR code with empty text, zero BCAST flag
    put_word(stim_q, OPC_RESYNC);
    put_word(stim_q, 16'(OP_NONE));
    put_word(stim_q, OPC_MAX + 16'd1);
    put_word(stim_q, OPC_RESYNC - 16'd1);
    put_word(stim_q, 16'(OP_DIRQ));
    put_word(stim_q, 16'(OP_DISC));
    put_word(stim_q, 16'(OP_RRQ));
    stim_q = {stim_q, NUL};
    put_word(stim_q, 16'(OP_ACK));
    put_word(stim_q, 16'hFFFF);
    put_word(stim_q, 16'(OP_DATA));
    put_word(stim_q, 16'h0000);
    put_word(stim_q, 16'h0000);
    put_word(stim_q, 16'(OP_ERROR));
    put_word(stim_q, 16'h0000);
    stim_q = {stim_q, NUL};
    put_word(stim_q, 16'(OP_BCAST));
    stim_q = {stim_q, NUL};
    stim_q = {stim_q, NUL};

    // random: mostly well-formed packets, some resync/unknown, truncated packets and noise
    random_start = stim_q.size();
    while (stim_q.size() < random_start + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      pkt.delete();
      if (pick < 80) begin
        build_packet(pkt, 4'($urandom_range(OP_RRQ, OP_DISC)), pick_len(), pick_len());
      end else if (pick < 86) begin
        put_word(pkt, OPC_RESYNC);
      end else if (pick < 92) begin
        if ($urandom_range(0, 7) == 0) put_word(pkt, 16'(OP_NONE));
        else put_word(pkt, 16'($urandom_range(int'(OPC_MAX) + 1, int'(OPC_RESYNC) - 1)));
      end else if (pick < 96) begin
        build_packet(pkt, 4'($urandom_range(OP_RRQ, OP_DISC)), pick_len(), pick_len());
        pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
      end else begin
        repeat ($urandom_range(1, 4)) pkt = {pkt, 8'($urandom)};
      end
      stim_q = {stim_q, pkt};
    end

    build_packet(stim_q, OP_ACK, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drive_stream();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes; checked %0d results: %0d data bytes, %0d packets, %0d unknown.",
             sb.n_bytes, sb.n_results, sb.n_text, sb.n_done, sb.n_unknown);
    $display("Packet types completed: %0d of 10, under bursty input and a stalling sink.",
             $countones(sb.types_done));
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
